### hw/rtl/bht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bht_pkg
// shared sizes, codes and types of the bucketed hash table engine
// ----------------------------------------------------------------------------
package bht_pkg;

  localparam int BUCKET_COUNT     = 32;
  localparam int SLOTS_PER_BUCKET = 3;
  localparam int TABLE_DEPTH      = BUCKET_COUNT * SLOTS_PER_BUCKET;

  localparam int BKT_W   = $clog2(BUCKET_COUNT);
  localparam int SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);

  // sum of four cubes of bytes stays below 2^26
  localparam int SUM_W      = 26;
  localparam int HASH_CNT_W = 3;

  localparam logic [SLOT_W-1:0]      LAST_SLOT  = SLOT_W'(SLOTS_PER_BUCKET - 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HASH = 6'b000010,
    S_MOD  = 6'b000100,
    S_RD   = 6'b001000,
    S_CHK  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] name_low;
    logic [63:0] name_mid;
    logic [31:0] name_high;
    logic [31:0] quantity;
  } record_t;

  localparam int REC_W = $bits(record_t);

endpackage
`default_nettype wire

### hw/rtl/bht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bht_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bucketed_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucketed_hash_table
// set-associative record store: search, insert and delete on a 4-byte key
// ----------------------------------------------------------------------------
// steps: the hash on the shared byte multiplier, taking the remainder, then a
//   read and a check per slot of the bucket scan through the ram read port,
//   and a finish state; an invalid key skips the scan
// one request at a time: a new one is taken only once the block is back in
//   idle, and later while the result is stalled
// reset: per-slot valid flops clear at once, the whole table reads empty and
//   the block is ready as soon as reset ends, no clearing pass
module bucketed_hash_table import bht_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [31:0]        in_key_id,
  input  wire logic [63:0]        in_name_low,
  input  wire logic [63:0]        in_name_mid,
  input  wire logic [31:0]        in_name_high,
  input  wire logic signed [31:0] in_quantity,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic [4:0]              out_bucket_index,
  output logic [1:0]              out_slot_index,
  output logic [31:0]             out_found_id,
  output logic [63:0]             out_found_name_low,
  output logic [63:0]             out_found_name_mid,
  output logic [31:0]             out_found_name_high,
  output logic signed [31:0]      out_found_quantity
);

  // sequencer and request registers
  state_t                 state_r, state_nxt;
  logic [1:0]             op_r;
  logic [31:0]            key_r;
  record_t                in_rec_r;

  // hash: shared multiplier and remainder
  logic [HASH_CNT_W-1:0]  hash_cnt_r, hash_cnt_nxt;
  logic [15:0]            sq_r, sq_nxt;
  logic [SUM_W-1:0]       acc_r, acc_nxt;
  logic [BKT_W-1:0]       bucket_r, bucket_nxt;

  // bucket scan
  logic [SLOT_W-1:0]      slot_cnt_r, slot_cnt_nxt;
  logic                   rd_valid_r;
  logic                   have_match_r, have_match_nxt;
  logic [SLOT_W-1:0]      match_slot_r, match_slot_nxt;
  record_t                match_rec_r, match_rec_nxt;
  logic                   have_empty_r, have_empty_nxt;
  logic [SLOT_W-1:0]      empty_slot_r, empty_slot_nxt;

  // slot occupancy, cleared by reset
  logic [TABLE_DEPTH-1:0] slot_valid_r;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_status_r;
  logic [BKT_W-1:0]       out_bucket_r;
  logic [SLOT_W-1:0]      out_slot_r;
  record_t                out_rec_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   fin_go;

  logic [7:0]             key_byte;
  logic [15:0]            mul_a;
  logic [23:0]            prod;
  logic [SUM_W-1:0]       bucket_mod;

  logic [ADDR_W-1:0]      slot_addr;
  logic [ADDR_W-1:0]      hit_addr;
  logic [ADDR_W-1:0]      fill_addr;
  record_t                rd_rec;

  logic [2:0]             res_status;
  logic [SLOT_W-1:0]      res_slot;
  record_t                res_rec;
  logic                   do_write;
  logic                   do_clear;

  logic [BKT_W+4:0]       bucket_ext;
  logic [SLOT_W+1:0]      slot_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign fin_go    = (state_r == S_FIN) && out_free;

  // shared multiplier: even step squares a byte, odd step cubes it
  assign key_byte = key_r[{hash_cnt_r[2:1], 3'b000} +: 8];
  assign mul_a    = hash_cnt_r[0] ? sq_r : {8'b0, key_byte};
  assign prod     = {8'b0, mul_a} * {16'b0, key_byte};

  // bucket count is a power of two, so the remainder is the low bits of the sum
  assign bucket_mod = acc_r % SUM_W'(BUCKET_COUNT);

  // entry address of the slot under scan, slot s of bucket b at b * slots + s
  assign slot_addr = ADDR_W'(bucket_r) * ADDR_W'(SLOTS_PER_BUCKET) + ADDR_W'(slot_cnt_r);
  assign hit_addr  = ADDR_W'(bucket_r) * ADDR_W'(SLOTS_PER_BUCKET) + ADDR_W'(match_slot_r);
  assign fill_addr = ADDR_W'(bucket_r) * ADDR_W'(SLOTS_PER_BUCKET) + ADDR_W'(empty_slot_r);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    hash_cnt_nxt   = hash_cnt_r;
    sq_nxt         = sq_r;
    acc_nxt        = acc_r;
    bucket_nxt     = bucket_r;
    slot_cnt_nxt   = slot_cnt_r;
    have_match_nxt = have_match_r;
    match_slot_nxt = match_slot_r;
    match_rec_nxt  = match_rec_r;
    have_empty_nxt = have_empty_r;
    empty_slot_nxt = empty_slot_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt      = S_HASH;
          hash_cnt_nxt   = '0;
          acc_nxt        = '0;
          bucket_nxt     = '0;
          slot_cnt_nxt   = '0;
          have_match_nxt = 1'b0;
          have_empty_nxt = 1'b0;
          match_slot_nxt = '0;
          empty_slot_nxt = '0;
        end
      end
      S_HASH: begin
        if (hash_cnt_r[0]) begin
          acc_nxt = acc_r + SUM_W'(prod);
        end else begin
          sq_nxt = prod[15:0];
        end
        hash_cnt_nxt = hash_cnt_r + 1'b1;
        if (hash_cnt_r == '1) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        bucket_nxt = bucket_mod[BKT_W-1:0];
        // a zero first key byte skips the scan
        state_nxt  = (key_r[7:0] == 8'd0) ? S_FIN : S_RD;
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!rd_valid_r) begin
          // highest-numbered empty slot wins
          have_empty_nxt = 1'b1;
          empty_slot_nxt = slot_cnt_r;
        end else if (!have_match_r && (rd_rec.key == key_r)) begin
          have_match_nxt = 1'b1;
          match_slot_nxt = slot_cnt_r;
          match_rec_nxt  = rd_rec;
        end
        slot_cnt_nxt = slot_cnt_r + 1'b1;
        state_nxt    = (slot_cnt_r == LAST_SLOT) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outcome of the request once the bucket is scanned
  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_rec    = '0;
    do_write   = 1'b0;
    do_clear   = 1'b0;
    if (key_r[7:0] == 8'd0) begin
      res_status = ST_INVALID;
    end else if (op_r == OP_INSERT) begin
      if (have_match_r) begin
        res_status = ST_DUPLICATE;
        res_slot   = match_slot_r;
        res_rec    = match_rec_r;
      end else if (!have_empty_r) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_OK;
        res_slot   = empty_slot_r;
        res_rec    = in_rec_r;
        do_write   = 1'b1;
      end
    end else if (!have_match_r) begin
      // search or delete with no match, and the unused code that behaves as a search
      res_status = ST_NOT_FOUND;
    end else begin
      res_status = ST_OK;
      res_slot   = match_slot_r;
      res_rec    = match_rec_r;
      do_clear   = (op_r == OP_DELETE);
    end
  end

  // record store
  bht_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (fin_go && do_write),
    .wr_addr (fill_addr),
    .wr_data (in_rec_r),
    .rd_en   (state_r == S_RD),
    .rd_addr (slot_addr),
    .rd_data (rd_rec)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      slot_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_go && do_write) begin
        slot_valid_r[fill_addr] <= 1'b1;
      end
      if (fin_go && do_clear) begin
        slot_valid_r[hit_addr] <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r               <= in_operation;
      key_r              <= in_key_id;
      in_rec_r.key       <= in_key_id;
      in_rec_r.name_low  <= in_name_low;
      in_rec_r.name_mid  <= in_name_mid;
      in_rec_r.name_high <= in_name_high;
      in_rec_r.quantity  <= in_quantity;
    end
    hash_cnt_r   <= hash_cnt_nxt;
    sq_r         <= sq_nxt;
    acc_r        <= acc_nxt;
    bucket_r     <= bucket_nxt;
    slot_cnt_r   <= slot_cnt_nxt;
    have_match_r <= have_match_nxt;
    match_slot_r <= match_slot_nxt;
    match_rec_r  <= match_rec_nxt;
    have_empty_r <= have_empty_nxt;
    empty_slot_r <= empty_slot_nxt;
    if (state_r == S_RD) begin
      // an entry never written or cleared reads as empty
      rd_valid_r <= slot_valid_r[slot_addr];
    end
    if (fin_go) begin
      out_status_r <= res_status;
      out_bucket_r <= bucket_r;
      out_slot_r   <= res_slot;
      out_rec_r    <= res_rec;
    end
  end

  // fit internal index widths to the fixed result fields
  assign bucket_ext = {5'b0, out_bucket_r};
  assign slot_ext   = {2'b0, out_slot_r};

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_bucket_index    = bucket_ext[4:0];
  assign out_slot_index      = slot_ext[1:0];
  assign out_found_id        = out_rec_r.key;
  assign out_found_name_low  = out_rec_r.name_low;
  assign out_found_name_mid  = out_rec_r.name_mid;
  assign out_found_name_high = out_rec_r.name_high;
  assign out_found_quantity  = out_rec_r.quantity;

endmodule
`default_nettype wire

### dv/bucketed_hash_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_hash_table_test
// self-checking bench for the bucketed hash table engine: a shadow copy of
// the slot store predicts every search, insert and delete, a driver offers
// queued requests with random gaps, a monitor stalls at random and checks
// each result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module bucketed_hash_table_test;
  import bht_pkg::*;

  // operation code that the block treats as a plain search
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int HOLD_CYCLES = 400;  // long receiver hold-off
  localparam int SETTLE      = 60;   // extra wait after the last result
  localparam int RANDOM_REQS = 400;
  localparam int POOL_SIZE   = 16;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    logic [63:0] name_low;
    logic [63:0] name_mid;
    logic [31:0] name_high;
    logic [31:0] quantity;
    int          gap;    // idle cycles before the request is offered
    bit          drain;  // wait for every outstanding result first
    bit          hold;   // start the long receiver hold-off when offered
  } request_t;

  typedef struct {
    logic [2:0]       status;
    logic [BKT_W-1:0] bucket;
    logic [1:0]       slot;
    record_t          rec;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_operation = '0;
  logic [31:0]        in_key_id = '0;
  logic [63:0]        in_name_low = '0;
  logic [63:0]        in_name_mid = '0;
  logic [31:0]        in_name_high = '0;
  logic signed [31:0] in_quantity = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic [4:0]         out_bucket_index;
  logic [1:0]         out_slot_index;
  logic [31:0]        out_found_id;
  logic [63:0]        out_found_name_low;
  logic [63:0]        out_found_name_mid;
  logic [31:0]        out_found_name_high;
  logic signed [31:0] out_found_quantity;

  // shadow copy of the slot store and the bench bookkeeping
  record_t     shadow_table [TABLE_DEPTH];
  request_t    outbox[$];
  reply_t      awaited_replies[$];
  logic [31:0] key_pool [POOL_SIZE];
  bit          calm_tx = 1'b0;
  int          fault_count = 0;
  int          results_seen = 0;
  int          status_tally [5];
  int          op_tally [4];

  // driver-side state
  int gap_left = 0;
  bit gap_armed = 1'b0;
  int hold_req = 0;

  // monitor-side state
  int stall_left = 0;
  int hold_left = 0;
  int hold_ack = 0;

  bucketed_hash_table uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_key_id           (in_key_id),
    .in_name_low         (in_name_low),
    .in_name_mid         (in_name_mid),
    .in_name_high        (in_name_high),
    .in_quantity         (in_quantity),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_bucket_index    (out_bucket_index),
    .out_slot_index      (out_slot_index),
    .out_found_id        (out_found_id),
    .out_found_name_low  (out_found_name_low),
    .out_found_name_mid  (out_found_name_mid),
    .out_found_name_high (out_found_name_high),
    .out_found_quantity  (out_found_quantity)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // bucket of a key: sum of the cubes of its four bytes, modulo bucket count
  function automatic logic [BKT_W-1:0] bucket_of(logic [31:0] key);
    logic [31:0] sum;
    logic [31:0] b;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      b = {24'b0, key[8*i +: 8]};
      sum += b * b * b;
    end
    return BKT_W'(sum % BUCKET_COUNT);
  endfunction

  // work out the result of one request and update the shadow store
  function automatic reply_t apply_request(request_t rq);
    reply_t rp;
    int     base;
    int     hit;
    int     free_slot;
    rp = '{status: ST_OK, bucket: bucket_of(rq.key), slot: '0, rec: '0};
    base = rp.bucket * SLOTS_PER_BUCKET;
    hit = -1;
    free_slot = -1;
    // first key byte zero: rejected before the bucket is even looked at
    if (rq.key[7:0] == 8'h00) begin
      rp.status = ST_INVALID;
      return rp;
    end
    // empty slot wins the highest index, a match the lowest
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (shadow_table[base+s].key[7:0] == 8'h00) begin
        free_slot = s;
      end else if (hit < 0 && shadow_table[base+s].key == rq.key) begin
        hit = s;
      end
    end
    if (rq.op == OP_INSERT) begin
      if (hit >= 0) begin
        rp.status = ST_DUPLICATE;
        rp.slot = 2'(hit);
        rp.rec = shadow_table[base+hit];
      end else if (free_slot < 0) begin
        rp.status = ST_FULL;
      end else begin
        shadow_table[base+free_slot] = '{key: rq.key, name_low: rq.name_low,
                                         name_mid: rq.name_mid,
                                         name_high: rq.name_high,
                                         quantity: rq.quantity};
        rp.slot = 2'(free_slot);
        rp.rec = shadow_table[base+free_slot];
      end
    end else if (hit < 0) begin
      rp.status = ST_NOT_FOUND;
    end else begin
      // search, delete and the unused code all report the matching record
      rp.slot = 2'(hit);
      rp.rec = shadow_table[base+hit];
      if (rq.op == OP_DELETE) begin
        shadow_table[base+hit] = '0;
      end
    end
    return rp;
  endfunction

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  task automatic queue_request(logic [1:0] op, logic [31:0] key, logic [63:0] nlo,
                               logic [63:0] nmid, logic [31:0] nhi, logic [31:0] qty);
    request_t rq;
    rq = '{op: op, key: key, name_low: nlo, name_mid: nmid, name_high: nhi,
           quantity: qty, gap: calm_tx ? 0 : $urandom_range(0, 19),
           drain: 1'b0, hold: 1'b0};
    outbox.push_back(rq);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // mostly keys from a pool crowded into a few buckets, so that hits,
  // duplicates and full buckets come up often; some fully random and some
  // invalid keys on top
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else if (r < 85) begin
      return $urandom() & 32'hFFFF_FF00;
    end
    return $urandom();
  endfunction

  function automatic logic [1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return OP_INSERT;
    end else if (r < 70) begin
      return OP_SEARCH;
    end else if (r < 95) begin
      return OP_DELETE;
    end
    return OP_UNUSED;
  endfunction

  // driver: offers queued requests, predicts each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      gap_armed = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_replies.push_back(apply_request('{op: in_operation, key: in_key_id,
          name_low: in_name_low, name_mid: in_name_mid, name_high: in_name_high,
          quantity: in_quantity, gap: 0, drain: 1'b0, hold: 1'b0}));
        op_tally[in_operation]++;
      end
      // a stalled transaction stays on the bus unchanged
      if (!(in_valid && in_stall)) begin
        if (outbox.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          if (!gap_armed) begin
            gap_left = outbox[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
            in_valid <= 1'b0;
          end else if (outbox[0].drain && awaited_replies.size() != 0) begin
            in_valid <= 1'b0;
          end else begin
            in_operation <= outbox[0].op;
            in_key_id    <= outbox[0].key;
            in_name_low  <= outbox[0].name_low;
            in_name_mid  <= outbox[0].name_mid;
            in_name_high <= outbox[0].name_high;
            in_quantity  <= outbox[0].quantity;
            in_valid     <= 1'b1;
            if (outbox[0].hold) begin
              hold_req <= hold_req + 1;
            end
            void'(outbox.pop_front());
            gap_armed = 1'b0;
          end
        end
      end
    end
  end

  // monitor: random stall per result, long hold-off on request, checking
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_status < 3'd5) begin
          status_tally[out_status]++;
        end
        if (awaited_replies.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result, expected none, got status %0d key %0h",
                   $time, out_status, out_found_id);
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", want.status, out_status);
          check_field("bucket_index", want.bucket, out_bucket_index);
          check_field("slot_index", want.slot, out_slot_index);
          check_field("found_id", want.rec.key, out_found_id);
          check_field("found_name_low", want.rec.name_low, out_found_name_low);
          check_field("found_name_mid", want.rec.name_mid, out_found_name_mid);
          check_field("found_name_high", want.rec.name_high, out_found_name_high);
          check_field("found_quantity", want.rec.quantity,
                      $unsigned(out_found_quantity));
        end
        // stall for the next result; every fourth stretch of 60 goes unstalled
        stall_left = ((results_seen / 60) % 4 == 2) ? 0 : $urandom_range(0, 19);
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      if (hold_ack != hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_ack = hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0) || (stall_left > 0);
    end
  end

  initial begin
    #1_000_000;
    $display("bucketed_hash_table: mismatch");
    $finish;
  end

  initial begin
    int         n;
    logic [31:0] k;
    for (int e = 0; e < TABLE_DEPTH; e++) begin
      shadow_table[e] = '0;
    end
    for (int i = 0; i < 5; i++) begin
      status_tally[i] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      op_tally[i] = 0;
    end

    // pool of valid keys packed into buckets 0 to 3
    n = 0;
    while (n < POOL_SIZE) begin
      k = $urandom();
      if (k[7:0] != 8'h00 && bucket_of(k) < 4) begin
        key_pool[n] = k;
        n++;
      end
    end

    // directed part; the four byte permutations of 01 02 03 04 share a bucket
    queue_request(OP_SEARCH, 32'h0403_0201, rand64(), rand64(), $urandom(), $urandom());
    queue_request(OP_INSERT, 32'h0000_0000, '0, '0, '0, '0);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, '1, '1, '1, 32'h8000_0000);
    queue_request(OP_INSERT, 32'h0403_0201, rand64(), rand64(), $urandom(), 32'h7FFF_FFFF);
    queue_request(OP_INSERT, 32'h0102_0304, rand64(), rand64(), $urandom(), $urandom());
    queue_request(OP_INSERT, 32'h0201_0403, rand64(), rand64(), $urandom(), $urandom());
    // bucket now full
    queue_request(OP_INSERT, 32'h0304_0102, rand64(), rand64(), $urandom(), $urandom());
    // duplicate key
    queue_request(OP_INSERT, 32'h0102_0304, rand64(), rand64(), $urandom(), $urandom());
    queue_request(OP_SEARCH, 32'h0201_0403, '0, '0, '0, '0);
    queue_request(OP_UNUSED, 32'h0403_0201, '1, '1, '1, '1);
    queue_request(OP_DELETE, 32'h0102_0304, rand64(), rand64(), $urandom(), $urandom());
    queue_request(OP_DELETE, 32'h0102_0304, '0, '0, '0, '0);
    // freed slot gets reused
    queue_request(OP_INSERT, 32'h0304_0102, '0, '0, '0, 32'h0000_0000);
    queue_request(OP_SEARCH, 32'hFFFF_FF00, '1, '1, '1, '1);
    queue_request(OP_DELETE, 32'hFFFF_FFFF, '0, '0, '0, '0);
    queue_request(OP_SEARCH, 32'hFFFF_FFFF, '0, '0, '0, '0);
    queue_request(OP_DELETE, 32'h1234_5600, '0, '0, '0, '0);
    queue_request(OP_UNUSED, 32'h8765_4321, '0, '0, '0, '0);
    queue_request(OP_INSERT, 32'h0000_0001, '0, '0, '0, 32'hFFFF_FFFF);
    queue_request(OP_UNUSED, 32'h0000_0000, '0, '0, '0, '0);

    // random part: drain pause at 100, receiver hold-off at 200 while the
    // sender keeps offering back to back
    for (int i = 0; i < RANDOM_REQS; i++) begin
      calm_tx = (i >= 200 && i < 260);
      queue_request(pick_op(), pick_key(), rand64(), rand64(), $urandom(), $urandom());
      if (i == 100) begin
        outbox[$].drain = 1'b1;
      end
      if (i == 200) begin
        outbox[$].hold = 1'b1;
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (outbox.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (awaited_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d requests (%0d search, %0d insert, %0d delete, %0d unused code)",
             results_seen, op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
    $display("results: %0d done, %0d not found, %0d duplicate, %0d full, %0d invalid key",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (fault_count == 0) begin
      $display("bucketed_hash_table: match");
    end else begin
      $display("bucketed_hash_table: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/bht_pkg.sv
hw/rtl/bht_ram.sv
hw/rtl/bucketed_hash_table.sv
dv/bucketed_hash_table_test.sv
